[rtl/generational_slot_lifetime_manager_assert.svh]
// ---------------------------------------------------------------------------
// generational slot lifetime manager assertion macros
// concurrent checks, empty when synthesized
// ---------------------------------------------------------------------------
`ifndef GENERATIONAL_SLOT_LIFETIME_MANAGER_ASSERT_SVH
`define GENERATIONAL_SLOT_LIFETIME_MANAGER_ASSERT_SVH

`ifndef SYNTHESIS
`define GSLM_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("gslm check failed");
`define GSLM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gslm check failed");
`else
`define GSLM_ASSERT(label, expr)
`define GSLM_ASSERT_IMP(label, ante, cons)
`endif

`endif

[rtl/gslm_pkg.sv]
// ---------------------------------------------------------------------------
// gslm_pkg
// shared codes, widths and types of the slot lifetime manager
// ---------------------------------------------------------------------------
package gslm_pkg;

  localparam int SLOTS_DEF         = 1024;
  localparam int MAX_EPOCHS_DEF    = 4;
  localparam int EPOCH_ENTRIES_DEF = 256;

  localparam int IN_DATA_W  = 144;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [2:0] REQ_ALLOC   = 3'd0;
  localparam logic [2:0] REQ_COMMIT  = 3'd1;
  localparam logic [2:0] REQ_CANCEL  = 3'd2;
  localparam logic [2:0] REQ_RETIRE  = 3'd3;
  localparam logic [2:0] REQ_SEAL    = 3'd4;
  localparam logic [2:0] REQ_COLLECT = 3'd5;
  localparam logic [2:0] REQ_QUERY   = 3'd6;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_CAPACITY = 3'd2;
  localparam logic [2:0] ST_FENCE    = 3'd3;
  localparam logic [2:0] ST_EPOCHS   = 3'd4;
  localparam logic [2:0] ST_STALE    = 3'd5;

  localparam logic [1:0] SS_INVALID   = 2'd0;
  localparam logic [1:0] SS_ALLOCATED = 2'd1;
  localparam logic [1:0] SS_ACTIVE    = 2'd2;
  localparam logic [1:0] SS_RETIRING  = 2'd3;

  localparam logic [1:0] EM_AVAILABLE = 2'd0;
  localparam logic [1:0] EM_OPEN      = 2'd1;
  localparam logic [1:0] EM_SEALED    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MASK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ECNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd2;

  localparam logic [2:0]  MASK_RST  = 3'd1;
  localparam logic [2:0]  ECNT_RST  = 3'd2;
  localparam logic [10:0] LIMIT_RST = 11'd1024;

  typedef struct packed {
    logic [10:0] recl;
    logic [1:0]  sstate;
    logic [31:0] gen;
    logic [9:0]  slot;
    logic [2:0]  status;
  } res_t;

endpackage

[rtl/gslm_ram.sv]
// ---------------------------------------------------------------------------
// gslm_ram
// one write port, one read port, registered read data
// ---------------------------------------------------------------------------
module gslm_ram #(
  parameter int W = 8,
  parameter int D = 2
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/generational_slot_lifetime_manager.sv]
// ---------------------------------------------------------------------------
// generational_slot_lifetime_manager
// generational handle allocator with epoch based reclamation
// ---------------------------------------------------------------------------
// After reset the slot table is cleared one entry a cycle, and no item is
// taken until that pass ends. Seal, unknown requests and failed allocates
// are answered straight from the idle state. Commit, cancel, retire and
// query read the slot table and then check the handle; allocate of a fresh
// slot reads and then writes the slot table, and allocate of a recycled
// slot first pops the free stack. Collect reads every retired entry of each
// sealed epoch once to check it and once more to free it, and stops on a
// stale entry. These steps follow from the single read port of the slot
// table and the epoch entry memory: a handle check reads before it writes.
// ---------------------------------------------------------------------------
`include "generational_slot_lifetime_manager_assert.svh"

module generational_slot_lifetime_manager #(
  parameter int SLOTS         = gslm_pkg::SLOTS_DEF,
  parameter int MAX_EPOCHS    = gslm_pkg::MAX_EPOCHS_DEF,
  parameter int EPOCH_ENTRIES = gslm_pkg::EPOCH_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // slot_index, handle_generation, graphics_fence, compute_fence, copy_fence
  input  logic [gslm_pkg::IN_DATA_W-1:0]  s_tdata,
  // req_type
  input  logic [gslm_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // status, out_slot, out_generation, slot_state, reclaimed
  output logic [gslm_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            cfg_we,
  input  logic [gslm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gslm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gslm_pkg::*;

  localparam int SW  = $clog2(SLOTS);
  localparam int EW  = $clog2(MAX_EPOCHS);
  localparam int NW  = $clog2(MAX_EPOCHS + 1);
  localparam int FW  = $clog2(EPOCH_ENTRIES + 1);
  localparam int ED  = MAX_EPOCHS * EPOCH_ENTRIES;
  localparam int EAW = $clog2(ED);
  localparam int SDW = 34;
  localparam int EDW = SW + 32;
  localparam int MOD_STEPS = MAX_EPOCHS / 2 + 1;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_APOP  = 4'd2;
  localparam logic [3:0] S_AMOD  = 4'd3;
  localparam logic [3:0] S_HCHK  = 4'd4;
  localparam logic [3:0] S_CEP   = 4'd5;
  localparam logic [3:0] S_CRS   = 4'd6;
  localparam logic [3:0] S_CCK   = 4'd7;
  localparam logic [3:0] S_CFS   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  function automatic logic [EW-1:0] ring_inc(input logic [EW-1:0] p,
                                             input logic [NW-1:0] n);
    logic [NW:0] x;
    x = (NW+1)'(p) + (NW+1)'(1);
    for (int k = 0; k < MOD_STEPS; k++) begin
      if (x >= (NW+1)'(n)) begin
        x = x - (NW+1)'(n);
      end
    end
    return EW'(x);
  endfunction

  function automatic logic [EAW-1:0] eaddr(input logic [EW-1:0] ep,
                                           input logic [FW-1:0] ix);
    return EAW'(32'(ep) * EPOCH_ENTRIES + 32'(ix));
  endfunction

  // configuration
  logic [2:0]  qmask;
  logic [2:0]  ecnt;
  logic [10:0] slimit;

  // control
  logic [3:0]    state, state_next;
  logic [SW-1:0] clr_addr, clr_addr_next;
  logic [SW:0]   free_top, free_top_next;
  logic [SW:0]   next_fresh, next_fresh_next;
  logic [FW-1:0] fill [MAX_EPOCHS];
  logic [FW-1:0] fill_next [MAX_EPOCHS];
  logic [1:0]    mode [MAX_EPOCHS];
  logic [1:0]    mode_next [MAX_EPOCHS];
  logic [31:0]   fences [MAX_EPOCHS][3];
  logic [31:0]   fences_next [MAX_EPOCHS][3];
  logic [EW-1:0] open_ptr, open_ptr_next;
  logic [EW-1:0] collect_ptr, collect_ptr_next;
  logic [NW-1:0] vcnt, vcnt_next;
  logic [FW-1:0] eidx, eidx_next;
  logic [10:0]   rec, rec_next;

  // item payload
  logic [2:0]    rq;
  logic [9:0]    rslot;
  logic [31:0]   rgen;
  logic [31:0]   rf [3];
  logic [SW-1:0] cur_slot, cur_slot_next;
  logic [31:0]   egen, egen_next;
  res_t          res, pend, outq;
  logic          done;

  // memory ports
  logic           s_we;
  logic [SW-1:0]  s_waddr, s_raddr;
  logic [SDW-1:0] s_wdata, s_rdata;
  logic           k_we;
  logic [SW-1:0]  k_waddr, k_raddr, k_wdata, k_rdata;
  logic           e_we;
  logic [EAW-1:0] e_waddr, e_raddr;
  logic [EDW-1:0] e_wdata, e_rdata;

  // decoded fields and helpers
  logic          s_fire, out_free;
  logic [2:0]    in_req;
  logic [9:0]    in_slot;
  logic [31:0]   in_gen;
  logic [31:0]   in_f [3];
  logic [31:0]   s_rd_gen, e_rd_gen, inc_gen, alloc_gen;
  logic [1:0]    s_rd_st, hs, hs_e;
  logic [SW-1:0] e_rd_slot;
  logic          slot_ok_r, fresh_ok, push_ok, fences_ok, fence_missing;
  logic [NW-1:0] ring_n;
  logic [EW-1:0] seal_nxt, col_nxt;
  logic [FW-1:0] open_fill, cur_fill, eidx_inc;

  gslm_ram #(.W(SDW), .D(SLOTS)) u_slot_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  gslm_ram #(.W(SW), .D(SLOTS)) u_stack_ram (
    .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
    .raddr(k_raddr), .rdata(k_rdata)
  );

  gslm_ram #(.W(EDW), .D(ED)) u_entry_ram (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  assign s_tready = (state == S_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {6'b0, outq};

  assign in_req  = s_tuser[2:0];
  assign in_slot = s_tdata[9:0];
  assign in_gen  = s_tdata[41:10];
  assign in_f[0] = s_tdata[73:42];
  assign in_f[1] = s_tdata[105:74];
  assign in_f[2] = s_tdata[137:106];

  assign s_rd_gen  = s_rdata[33:2];
  assign s_rd_st   = s_rdata[1:0];
  assign e_rd_slot = e_rdata[SW-1:0];
  assign e_rd_gen  = e_rdata[EDW-1:SW];
  assign slot_ok_r = 32'(rslot) < 32'(SLOTS);
  assign hs        = (slot_ok_r && s_rd_gen == rgen) ? s_rd_st : SS_INVALID;
  assign hs_e      = (s_rd_gen == egen) ? s_rd_st : SS_INVALID;
  assign inc_gen   = s_rd_gen + 32'd1;
  assign alloc_gen = (inc_gen == 32'd0) ? 32'd1 : inc_gen;
  assign fresh_ok  = (32'(next_fresh) < 32'(slimit)) && (32'(next_fresh) < 32'(SLOTS));
  assign push_ok   = 32'(free_top) < 32'(SLOTS);
  assign open_fill = fill[open_ptr];
  assign cur_fill  = fill[collect_ptr];
  assign eidx_inc  = eidx + FW'(1);
  assign seal_nxt  = ring_inc(open_ptr, ring_n);
  assign col_nxt   = ring_inc(collect_ptr, ring_n);

  assign fence_missing = (qmask[0] && in_f[0] == 32'd0) || (qmask[1] && in_f[1] == 32'd0)
                      || (qmask[2] && in_f[2] == 32'd0);
  assign fences_ok = (fences[collect_ptr][0] == 32'd0 || rf[0] >= fences[collect_ptr][0])
                  && (fences[collect_ptr][1] == 32'd0 || rf[1] >= fences[collect_ptr][1])
                  && (fences[collect_ptr][2] == 32'd0 || rf[2] >= fences[collect_ptr][2]);

  always_comb begin
    if (ecnt < 3'd2) begin
      ring_n = NW'(2);
    end else if (32'(ecnt) > 32'(MAX_EPOCHS)) begin
      ring_n = NW'(MAX_EPOCHS);
    end else begin
      ring_n = NW'(ecnt);
    end
  end

  always_comb begin
    state_next       = state;
    clr_addr_next    = clr_addr;
    free_top_next    = free_top;
    next_fresh_next  = next_fresh;
    fill_next        = fill;
    mode_next        = mode;
    fences_next      = fences;
    open_ptr_next    = open_ptr;
    collect_ptr_next = collect_ptr;
    vcnt_next        = vcnt;
    eidx_next        = eidx;
    rec_next         = rec;
    cur_slot_next    = cur_slot;
    egen_next        = egen;
    done             = 1'b0;
    res.status       = ST_OK;
    res.slot         = (state == S_IDLE) ? in_slot : rslot;
    res.gen          = 32'd0;
    res.sstate       = SS_INVALID;
    res.recl         = 11'd0;
    s_we             = 1'b0;
    s_waddr          = cur_slot;
    s_wdata          = '0;
    s_raddr          = cur_slot;
    k_we             = 1'b0;
    k_waddr          = free_top[SW-1:0];
    k_wdata          = cur_slot;
    k_raddr          = SW'(free_top - (SW+1)'(1));
    e_we             = 1'b0;
    e_waddr          = eaddr(open_ptr, open_fill);
    e_wdata          = {rgen, cur_slot};
    e_raddr          = eaddr(collect_ptr, eidx);

    unique case (state)
      S_CLEAR: begin
        s_we          = 1'b1;
        s_waddr       = clr_addr;
        clr_addr_next = clr_addr + SW'(1);
        if (clr_addr == SW'(SLOTS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_fire) begin
          cur_slot_next = SW'(in_slot);
          s_raddr       = SW'(in_slot);
          unique case (in_req)
            REQ_ALLOC: begin
              if (free_top != '0) begin
                free_top_next = free_top - (SW+1)'(1);
                state_next    = S_APOP;
              end else if (fresh_ok) begin
                cur_slot_next   = next_fresh[SW-1:0];
                s_raddr         = next_fresh[SW-1:0];
                next_fresh_next = next_fresh + (SW+1)'(1);
                state_next      = S_AMOD;
              end else begin
                done       = 1'b1;
                res.status = ST_CAPACITY;
              end
            end
            REQ_COMMIT, REQ_CANCEL, REQ_RETIRE, REQ_QUERY: begin
              state_next = S_HCHK;
            end
            REQ_SEAL: begin
              done = 1'b1;
              if (open_fill == '0) begin
                res.status = ST_OK;
              end else if (fence_missing) begin
                res.status = ST_FENCE;
              end else if (mode[seal_nxt] != EM_AVAILABLE) begin
                res.status = ST_EPOCHS;
              end else begin
                for (int q = 0; q < 3; q++) begin
                  fences_next[open_ptr][q] = in_f[q];
                  fences_next[seal_nxt][q] = 32'd0;
                end
                mode_next[open_ptr] = EM_SEALED;
                mode_next[seal_nxt] = EM_OPEN;
                open_ptr_next       = seal_nxt;
              end
            end
            REQ_COLLECT: begin
              vcnt_next  = '0;
              rec_next   = 11'd0;
              state_next = S_CEP;
            end
            default: begin
              done       = 1'b1;
              res.status = ST_INVALID;
            end
          endcase
        end
      end
      S_APOP: begin
        cur_slot_next = k_rdata;
        s_raddr       = k_rdata;
        state_next    = S_AMOD;
      end
      S_AMOD: begin
        s_we     = 1'b1;
        s_wdata  = {alloc_gen, SS_ALLOCATED};
        done     = 1'b1;
        res.slot = 10'(cur_slot);
        res.gen  = alloc_gen;
      end
      S_HCHK: begin
        done = 1'b1;
        unique case (rq)
          REQ_COMMIT: begin
            if (hs != SS_ALLOCATED) begin
              res.status = ST_INVALID;
            end else begin
              s_we    = 1'b1;
              s_wdata = {rgen, SS_ACTIVE};
            end
          end
          REQ_CANCEL: begin
            if (hs != SS_ALLOCATED) begin
              res.status = ST_INVALID;
            end else begin
              s_we    = 1'b1;
              s_wdata = {rgen, SS_INVALID};
              if (push_ok) begin
                k_we          = 1'b1;
                free_top_next = free_top + (SW+1)'(1);
              end
            end
          end
          REQ_RETIRE: begin
            if (hs != SS_ACTIVE) begin
              res.status = ST_INVALID;
            end else if (open_fill == FW'(EPOCH_ENTRIES)) begin
              res.status = ST_CAPACITY;
            end else begin
              e_we                = 1'b1;
              fill_next[open_ptr] = open_fill + FW'(1);
              s_we                = 1'b1;
              s_wdata             = {rgen, SS_RETIRING};
            end
          end
          default: begin
            res.sstate = hs;
          end
        endcase
      end
      S_CEP: begin
        if (vcnt >= ring_n || mode[collect_ptr] != EM_SEALED || !fences_ok) begin
          done     = 1'b1;
          res.recl = rec;
        end else if (cur_fill == '0) begin
          mode_next[collect_ptr] = EM_AVAILABLE;
          for (int q = 0; q < 3; q++) begin
            fences_next[collect_ptr][q] = 32'd0;
          end
          collect_ptr_next = col_nxt;
          vcnt_next        = vcnt + NW'(1);
        end else begin
          eidx_next  = '0;
          e_raddr    = eaddr(collect_ptr, '0);
          state_next = S_CRS;
        end
      end
      S_CRS: begin
        s_raddr       = e_rd_slot;
        cur_slot_next = e_rd_slot;
        egen_next     = e_rd_gen;
        state_next    = S_CCK;
      end
      S_CCK: begin
        if (hs_e != SS_RETIRING) begin
          done       = 1'b1;
          res.status = ST_STALE;
          res.recl   = rec;
        end else if (eidx_inc == cur_fill) begin
          eidx_next  = '0;
          e_raddr    = eaddr(collect_ptr, '0);
          state_next = S_CFS;
        end else begin
          eidx_next  = eidx_inc;
          e_raddr    = eaddr(collect_ptr, eidx_inc);
          state_next = S_CRS;
        end
      end
      S_CFS: begin
        s_we     = 1'b1;
        s_waddr  = e_rd_slot;
        s_wdata  = {e_rd_gen, SS_INVALID};
        k_wdata  = e_rd_slot;
        rec_next = rec + 11'd1;
        if (push_ok) begin
          k_we          = 1'b1;
          free_top_next = free_top + (SW+1)'(1);
        end
        if (eidx_inc == cur_fill) begin
          fill_next[collect_ptr] = '0;
          mode_next[collect_ptr] = EM_AVAILABLE;
          for (int q = 0; q < 3; q++) begin
            fences_next[collect_ptr][q] = 32'd0;
          end
          collect_ptr_next = col_nxt;
          vcnt_next        = vcnt + NW'(1);
          state_next       = S_CEP;
        end else begin
          eidx_next = eidx_inc;
          e_raddr   = eaddr(collect_ptr, eidx_inc);
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (done) begin
      state_next = out_free ? S_IDLE : S_OUT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      free_top    <= '0;
      next_fresh  <= '0;
      open_ptr    <= '0;
      collect_ptr <= '0;
      m_tvalid    <= 1'b0;
      qmask       <= MASK_RST;
      ecnt        <= ECNT_RST;
      slimit      <= LIMIT_RST;
      for (int e = 0; e < MAX_EPOCHS; e++) begin
        fill[e] <= '0;
        mode[e] <= (e == 0) ? EM_OPEN : EM_AVAILABLE;
        for (int q = 0; q < 3; q++) begin
          fences[e][q] <= 32'd0;
        end
      end
    end else begin
      state       <= state_next;
      clr_addr    <= clr_addr_next;
      free_top    <= free_top_next;
      next_fresh  <= next_fresh_next;
      open_ptr    <= open_ptr_next;
      collect_ptr <= collect_ptr_next;
      fill        <= fill_next;
      mode        <= mode_next;
      fences      <= fences_next;
      if ((done || state == S_OUT) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MASK:  qmask  <= cfg_data[2:0];
          CFG_ECNT:  ecnt   <= cfg_data[2:0];
          CFG_LIMIT: slimit <= cfg_data;
          default:   ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    vcnt     <= vcnt_next;
    eidx     <= eidx_next;
    rec      <= rec_next;
    cur_slot <= cur_slot_next;
    egen     <= egen_next;
    if (s_fire) begin
      rq    <= in_req;
      rslot <= in_slot;
      rgen  <= in_gen;
      rf    <= in_f;
    end
    if (done && !out_free) begin
      pend <= res;
    end
    if (out_free) begin
      if (state == S_OUT) begin
        outq <= pend;
      end else if (done) begin
        outq <= res;
      end
    end
  end

  `GSLM_ASSERT(a_free_top_bound, 32'(free_top) <= 32'(SLOTS))
  `GSLM_ASSERT(a_fresh_bound, 32'(next_fresh) <= 32'(SLOTS))
  `GSLM_ASSERT(a_open_epoch_open, mode[open_ptr] == EM_OPEN)
  `GSLM_ASSERT_IMP(a_pending_held, state == S_OUT, m_tvalid)

endmodule
